>>> src/random_slot_bitmap_allocator_unit_assert.svh
// Assertion macros for the random slot bitmap allocator.
// Included by the RTL files that carry concurrent checks; needs no package.
`ifndef RANDOM_SLOT_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH
`define RANDOM_SLOT_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while in reset
`define RSBA_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("rsba check failed");
// Next-cycle implication, disabled while in reset
`define RSBA_ASSERT_NXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("rsba check failed");
`else
`define RSBA_ASSERT_IMP(label, clk, rst_n, cond, prop)
`define RSBA_ASSERT_NXT(label, clk, rst_n, cond, prop)
`endif

`endif

>>> src/rsba_pkg.sv
// Shared types and constants of the random slot bitmap allocator.
// No dependencies; used by the controller, the datapath and the top level.
package rsba_pkg;

    // Slots examined per search cycle
    localparam int GRP_SIZE = 4;
    localparam int POS_W = 2;

    // Modulo: 32-bit draw consumed four bits a cycle
    localparam int RAND_W = 32;
    localparam int DIV_BITS = 4;
    localparam int DIV_STEPS = RAND_W / DIV_BITS;
    localparam int DIV_STEP_W = $clog2(DIV_STEPS);

    localparam logic [RAND_W-1:0] LFSR_TAPS = 32'hD000_0001;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_NONE    = 2'd1,
        STATUS_DBLFREE = 2'd2
    } status_t;

    typedef struct packed {
        logic alloc_none;
        logic free_slot;
        logic alloc_begin;
        logic div_step;
        logic srch_step;
    } rsba_cmd_t;

    typedef struct packed {
        logic avail_zero;
        logic found;
    } rsba_stat_t;

endpackage

>>> src/rsba_ctrl.sv
// Controller of the random slot bitmap allocator: sequences modulo and search.
// Depends on rsba_pkg for the command and status structs.
module rsba_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                req_type,
    input  rsba_pkg::rsba_stat_t stat,
    output rsba_pkg::rsba_cmd_t  cmd,
    output logic                busy,
    output logic                done
);
    import rsba_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_SRCH = 4'b0100,
        ST_RESP = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    logic [DIV_STEP_W-1:0]   step_reg, step_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (req_type)
                    begin
                        cmd.free_slot = 1'b1;
                        state_next    = ST_RESP;
                    end
                    else if (stat.avail_zero)
                    begin
                        cmd.alloc_none = 1'b1;
                        state_next     = ST_RESP;
                    end
                    else
                    begin
                        cmd.alloc_begin = 1'b1;
                        step_next       = '0;
                        state_next      = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == DIV_STEP_W'(DIV_STEPS - 1))
                    state_next = ST_SRCH;
            end
            ST_SRCH:
            begin
                cmd.srch_step = 1'b1;
                if (stat.found)
                    state_next = ST_RESP;
            end
            ST_RESP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_RESP);

endmodule

>>> src/rsba_dpath.sv
// Datapath of the random slot bitmap allocator: free map, LFSR, modulo, search.
// Depends on rsba_pkg; driven by rsba_ctrl commands.
module rsba_dpath #(
    parameter int SLOT_COUNT = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rsba_pkg::rsba_cmd_t  cmd,
    output rsba_pkg::rsba_stat_t stat,
    input  logic [4:0]           slot_index,
    input  logic                 seed_we,
    input  logic [31:0]          seed_data,
    output logic                 granted,
    output logic [4:0]           granted_slot,
    output logic [1:0]           status,
    output logic [5:0]           free_count
);
    import rsba_pkg::*;

    localparam int GROUPS   = (SLOT_COUNT + GRP_SIZE - 1) / GRP_SIZE;
    localparam int GRP_W    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int PAD_BITS = (2 ** GRP_W) * GRP_SIZE;

    logic [SLOT_COUNT-1:0] free_map_reg, free_map_next;
    logic [RAND_W-1:0]     rand_reg, rand_next;
    logic [RAND_W-1:0]     div_reg, div_next;
    logic [4:0]            k_reg, k_next;
    logic [GRP_W-1:0]      grp_reg, grp_next;
    logic [5:0]            count_reg, count_next;
    logic                  granted_reg, granted_next;
    logic [4:0]            slot_reg, slot_next;
    status_t               status_reg, status_next;

    logic [31:0]           map32;
    logic [PAD_BITS-1:0]   map_pad;
    logic [RAND_W-1:0]     rand_adv;
    logic [4:0]            k_div;
    logic [RAND_W-1:0]     div_shift;
    logic [GRP_SIZE-1:0]   grp_bits;
    logic [2:0]            grp_pop;
    logic [POS_W-1:0]      grp_pos;
    logic                  found;
    logic [4:0]            found_slot;
    logic                  in_range;
    logic                  already_free;

    function automatic logic [RAND_W-1:0] lfsr_next(input logic [RAND_W-1:0] s);
        logic [RAND_W-1:0] r;
        r = s >> 1;
        if (s[0])
            r = r ^ LFSR_TAPS;
        return r;
    endfunction

    assign map32    = 32'(free_map_reg);
    assign map_pad  = PAD_BITS'(free_map_reg);
    assign rand_adv = lfsr_next(rand_reg);

    // Restoring remainder, four dividend bits per cycle, MSB first
    always_comb
    begin
        logic [5:0] tmp;
        k_div     = k_reg;
        div_shift = div_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            tmp       = {k_div, div_shift[RAND_W-1]};
            div_shift = div_shift << 1;
            if (tmp >= count_reg)
                tmp = tmp - count_reg;
            k_div = tmp[4:0];
        end
    end

    // One group of slots per cycle: skip it or pick the k-th free bit inside
    always_comb
    begin
        logic [2:0] seen;
        logic       hit;
        grp_bits = map_pad[grp_reg * GRP_SIZE +: GRP_SIZE];
        grp_pop  = '0;
        for (int i = 0; i < GRP_SIZE; i++)
            grp_pop = grp_pop + 3'(grp_bits[i]);
        found   = (k_reg < 5'(grp_pop));
        grp_pos = '0;
        seen    = '0;
        hit     = 1'b0;
        for (int j = 0; j < GRP_SIZE; j++)
        begin
            if (grp_bits[j] && !hit)
            begin
                if (seen == 3'(k_reg[POS_W-1:0]))
                begin
                    grp_pos = POS_W'(j);
                    hit     = 1'b1;
                end
                seen = seen + 1'b1;
            end
        end
    end

    assign found_slot   = 5'({grp_reg, grp_pos});
    assign in_range     = ({1'b0, slot_index} < 6'(SLOT_COUNT));
    assign already_free = map32[slot_index];

    always_comb
    begin
        free_map_next = free_map_reg;
        rand_next     = rand_reg;
        div_next      = div_reg;
        k_next        = k_reg;
        grp_next      = grp_reg;
        count_next    = count_reg;
        granted_next  = granted_reg;
        slot_next     = slot_reg;
        status_next   = status_reg;

        if (seed_we)
            rand_next = (seed_data == '0) ? RAND_W'(1) : seed_data;

        if (cmd.alloc_none)
        begin
            granted_next = 1'b0;
            slot_next    = '0;
            status_next  = STATUS_NONE;
        end

        if (cmd.free_slot)
        begin
            granted_next  = 1'b0;
            slot_next     = '0;
            status_next   = already_free ? STATUS_DBLFREE : STATUS_OK;
            free_map_next = SLOT_COUNT'(map32 | (32'd1 << slot_index));
            if (in_range && !already_free)
                count_next = count_reg + 1'b1;
        end

        if (cmd.alloc_begin)
        begin
            rand_next = rand_adv;
            div_next  = rand_adv;
            k_next    = '0;
            grp_next  = '0;
        end

        if (cmd.div_step)
        begin
            div_next = div_shift;
            k_next   = k_div;
        end

        if (cmd.srch_step)
        begin
            if (found)
            begin
                free_map_next = SLOT_COUNT'(map32 & ~(32'd1 << found_slot));
                count_next    = count_reg - 1'b1;
                granted_next  = 1'b1;
                slot_next     = found_slot;
                status_next   = STATUS_OK;
            end
            else
            begin
                k_next   = k_reg - 5'(grp_pop);
                grp_next = grp_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_map_reg <= '1;
            rand_reg     <= RAND_W'(1);
            count_reg    <= 6'(SLOT_COUNT);
            granted_reg  <= 1'b0;
            slot_reg     <= '0;
            status_reg   <= STATUS_OK;
        end
        else
        begin
            free_map_reg <= free_map_next;
            rand_reg     <= rand_next;
            count_reg    <= count_next;
            granted_reg  <= granted_next;
            slot_reg     <= slot_next;
            status_reg   <= status_next;
        end
    end

    // Working registers of the modulo and search; no reset needed
    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        k_reg   <= k_next;
        grp_reg <= grp_next;
    end

    assign stat.avail_zero = (count_reg == '0);
    assign stat.found      = found;

    assign granted      = granted_reg;
    assign granted_slot = slot_reg;
    assign status       = status_reg;
    assign free_count   = count_reg;

endmodule

>>> src/random_slot_bitmap_allocator_unit.sv
// Random slot bitmap allocator, top level: controller plus datapath.
// Depends on rsba_pkg, rsba_ctrl, rsba_dpath and the assertion macro header.
//
// Usage: a request word (req_type, slot_index) is taken at a clock edge where
// start is high and busy is low. req_type 0 allocates a random free slot,
// req_type 1 frees slot_index. Each request gives one result word on granted,
// granted_slot, status and free_count, marked by done for exactly one cycle;
// the receiver must take it then, it cannot stall the block.
// Free requests and allocations with no slot free show done in the cycle
// after acceptance.
// An allocation steps the LFSR, runs the modulo (four dividend bits per
// cycle through one 6-bit compare-subtract chain), searches the free map
// (four slots per cycle) and then enters the result cycle.
// The seed is to be written with seed_we/seed_data only while idle (the
// block itself does not enforce this); it loads the LFSR at once (a zero
// seed loads 1).
// Reset marks every slot free, loads the LFSR with 1 and leaves the block idle.
module random_slot_bitmap_allocator_unit #(
    parameter int SLOT_COUNT = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        req_type,
    input  logic [4:0]  slot_index,
    input  logic        seed_we,
    input  logic [31:0] seed_data,
    output logic        done,
    output logic        granted,
    output logic [4:0]  granted_slot,
    output logic [1:0]  status,
    output logic [5:0]  free_count
);
    import rsba_pkg::*;

`include "random_slot_bitmap_allocator_unit_assert.svh"

    rsba_cmd_t  cmd;
    rsba_stat_t stat;

    rsba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done)
    );

    rsba_dpath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .slot_index   (slot_index),
        .seed_we      (seed_we),
        .seed_data    (seed_data),
        .granted      (granted),
        .granted_slot (granted_slot),
        .status       (status),
        .free_count   (free_count)
    );

    // A grant always reports ok and a refusal never names a slot
    `RSBA_ASSERT_IMP(a_grant_ok, clk, rst_n, done && granted, status == STATUS_OK)
    `RSBA_ASSERT_IMP(a_nogrant_slot0, clk, rst_n, done && !granted, granted_slot == '0)
    // Free count never exceeds the slot count
    `RSBA_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, free_count <= 6'(SLOT_COUNT))
    // An accepted request holds the block busy, and done lasts one cycle
    `RSBA_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `RSBA_ASSERT_NXT(a_done_pulse, clk, rst_n, done, !done && !busy)

endmodule
